// File: design/rfg_pkg.sv
// ----------------------------------------------------------------------------
// Remote encoder frame generator package
// Shared types, register codes and reset values for the frame generator.
// ----------------------------------------------------------------------------
package rfg_pkg;

  // Frame layout
  localparam int unsigned AddrWidth  = 4;
  localparam int unsigned DataWidth  = 8;
  localparam int unsigned FrameBits  = AddrWidth + DataWidth;
  localparam int unsigned BitIdxWidth = $clog2(FrameBits);
  localparam int unsigned LenWidth   = 16;
  localparam int unsigned RepWidth   = 4;

  // Segment timer width default
  localparam int unsigned TimerWidthDefault = 16;

  // Configuration port
  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = LenWidth;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_STATION_ADDRESS = 3'd0,
    REG_NARROW_TICKS    = 3'd1,
    REG_WIDE_TICKS      = 3'd2,
    REG_SYNC_LOW_TICKS  = 3'd3,
    REG_REPEAT_COUNT    = 3'd4
  } reg_idx_e;

  // Register reset values
  localparam logic [AddrWidth-1:0] StationAddressReset = 4'd0;
  localparam logic [LenWidth-1:0]  NarrowTicksReset    = 16'd520;
  localparam logic [LenWidth-1:0]  WideTicksReset      = 16'd1560;
  localparam logic [LenWidth-1:0]  SyncLowTicksReset   = 16'd17000;
  localparam logic [RepWidth-1:0]  RepeatCountReset    = 4'd4;

  // Transaction queue depth between front and back
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [AddrWidth-1:0] station_address;
    logic [LenWidth-1:0]  narrow_ticks;
    logic [LenWidth-1:0]  wide_ticks;
    logic [LenWidth-1:0]  sync_low_ticks;
    logic [RepWidth-1:0]  repeat_count;
  } cfg_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_e;

  typedef struct packed {
    op_e                  op;
    logic [FrameBits-1:0] word;
  } qentry_t;

endpackage

// File: design/rfg_front.sv
// ----------------------------------------------------------------------------
// Remote encoder frame generator front end
// Accepts input transactions, classifies them and builds the frame word.
// ----------------------------------------------------------------------------
module rfg_front (
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     command_i,
  input  logic [rfg_pkg::DataWidth-1:0] data_byte_i,
  input  logic [rfg_pkg::AddrWidth-1:0] station_address_i,
  output logic                     push_o,
  output rfg_pkg::qentry_t         push_entry_o,
  input  logic                     queue_full_i
);
  import rfg_pkg::*;

  // Hold the input side while the queue has no room
  assign in_stall_o = queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

  // Decode the command and assemble the word, address in the low nibble
  always_comb begin
    push_entry_o.word = {data_byte_i, station_address_i};
    unique case (command_i)
      1'b1:    push_entry_o.op = OP_LOAD;
      default: push_entry_o.op = OP_TICK;
    endcase
  end

endmodule

// File: design/rfg_queue.sv
// ----------------------------------------------------------------------------
// Remote encoder frame generator queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module rfg_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  rfg_pkg::qentry_t push_entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             pop_valid_o,
  output rfg_pkg::qentry_t pop_entry_o
);
  import rfg_pkg::*;

  localparam int unsigned PtrWidth = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntWidth = $clog2(QueueDepth + 1);

  qentry_t               mem_q [QueueDepth];
  logic [PtrWidth-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrWidth-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0]   count_q, count_d;

  assign full_o      = (count_q == CntWidth'(QueueDepth));
  assign pop_valid_o = (count_q != '0);
  assign pop_entry_o = mem_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// File: design/rfg_back.sv
// ----------------------------------------------------------------------------
// Remote encoder frame generator back end
// Runs the frame waveform sequencer and holds the result register.
// ----------------------------------------------------------------------------
module rfg_back #(
  parameter int unsigned TIMER_WIDTH = rfg_pkg::TimerWidthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rfg_pkg::cfg_t    cfg_i,
  input  logic             pop_valid_i,
  input  rfg_pkg::qentry_t pop_entry_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             line_level_o,
  output logic             busy_res_o,
  output logic             load_refused_o
);
  import rfg_pkg::*;

  typedef enum logic [6:0] {
    PH_IDLE       = 7'b0000001,
    PH_MARK0      = 7'b0000010,
    PH_SPACE0     = 7'b0000100,
    PH_MARK1      = 7'b0001000,
    PH_SPACE1     = 7'b0010000,
    PH_SYNC_MARK  = 7'b0100000,
    PH_SYNC_SPACE = 7'b1000000
  } phase_e;

  localparam logic [BitIdxWidth-1:0] LastBit = BitIdxWidth'(FrameBits - 1);

  phase_e                   phase_q, phase_d;
  logic [FrameBits-1:0]     word_q, word_d;
  logic [BitIdxWidth-1:0]   bit_idx_q, bit_idx_d;
  logic [RepWidth-1:0]      repeats_q, repeats_d;
  logic [TIMER_WIDTH-1:0]   timer_q, timer_d;
  logic                     out_valid_q, out_valid_d;
  logic                     level_q, level_d;
  logic                     busy_q, busy_d;
  logic                     refused_q, refused_d;

  logic                     fire;
  logic                     sending;
  logic                     cur_bit;
  logic [LenWidth-1:0]      seg_len;
  logic [LenWidth-1:0]      seg_len_eff;
  logic                     seg_level;
  logic [TIMER_WIDTH-1:0]   timer_inc;
  logic                     seg_done;

  // Take one transaction whenever the result register can accept it
  assign fire    = pop_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o   = fire;
  assign sending = (phase_q != PH_IDLE);
  assign cur_bit = word_q[bit_idx_q];

  // Select level and length of the current segment
  always_comb begin
    unique case (phase_q)
      PH_MARK0, PH_MARK1: begin
        seg_level = 1'b1;
        seg_len   = cur_bit ? cfg_i.wide_ticks : cfg_i.narrow_ticks;
      end
      PH_SPACE0, PH_SPACE1: begin
        seg_level = 1'b0;
        seg_len   = cur_bit ? cfg_i.narrow_ticks : cfg_i.wide_ticks;
      end
      PH_SYNC_MARK: begin
        seg_level = 1'b1;
        seg_len   = cfg_i.narrow_ticks;
      end
      PH_SYNC_SPACE: begin
        seg_level = 1'b0;
        seg_len   = cfg_i.sync_low_ticks;
      end
      default: begin
        seg_level = 1'b0;
        seg_len   = cfg_i.narrow_ticks;
      end
    endcase
  end

  // A zero length counts as one tick
  assign seg_len_eff = (seg_len == '0) ? LenWidth'(1) : seg_len;
  assign timer_inc   = timer_q + 1'b1;
  assign seg_done    = (timer_inc >= TIMER_WIDTH'(seg_len_eff));

  // Sequencer and result
  always_comb begin
    phase_d     = phase_q;
    word_d      = word_q;
    bit_idx_d   = bit_idx_q;
    repeats_d   = repeats_q;
    timer_d     = timer_q;
    out_valid_d = out_valid_q;
    level_d     = level_q;
    busy_d      = busy_q;
    refused_d   = refused_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (fire) begin
      out_valid_d = 1'b1;
      level_d     = 1'b0;
      busy_d      = 1'b0;
      refused_d   = 1'b0;
      unique case (pop_entry_i.op)
        OP_LOAD: begin
          busy_d = 1'b1;
          if (sending) begin
            // Drop the load, frame goes on
            refused_d = 1'b1;
          end else begin
            word_d    = pop_entry_i.word;
            repeats_d = (cfg_i.repeat_count == '0) ? RepWidth'(1) : cfg_i.repeat_count;
            bit_idx_d = '0;
            timer_d   = '0;
            phase_d   = PH_MARK0;
          end
        end
        default: begin
          if (sending) begin
            busy_d  = 1'b1;
            level_d = seg_level;
            timer_d = timer_inc;
            if (seg_done) begin
              timer_d = '0;
              unique case (phase_q)
                PH_MARK0:     phase_d = PH_SPACE0;
                PH_SPACE0:    phase_d = PH_MARK1;
                PH_MARK1:     phase_d = PH_SPACE1;
                PH_SPACE1: begin
                  if (bit_idx_q >= LastBit) begin
                    phase_d = PH_SYNC_MARK;
                  end else begin
                    bit_idx_d = bit_idx_q + 1'b1;
                    phase_d   = PH_MARK0;
                  end
                end
                PH_SYNC_MARK: phase_d = PH_SYNC_SPACE;
                default: begin
                  // End of frame: repeat or go idle
                  bit_idx_d = '0;
                  if (repeats_q <= RepWidth'(1)) begin
                    repeats_d = '0;
                    phase_d   = PH_IDLE;
                  end else begin
                    repeats_d = repeats_q - 1'b1;
                    phase_d   = PH_MARK0;
                  end
                end
              endcase
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      word_q      <= '0;
      bit_idx_q   <= '0;
      repeats_q   <= '0;
      timer_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      word_q      <= word_d;
      bit_idx_q   <= bit_idx_d;
      repeats_q   <= repeats_d;
      timer_q     <= timer_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    level_q   <= level_d;
    busy_q    <= busy_d;
    refused_q <= refused_d;
  end

  assign out_valid_o    = out_valid_q;
  assign line_level_o   = level_q;
  assign busy_res_o     = busy_q;
  assign load_refused_o = refused_q;

endmodule

// File: design/remote_encoder_frame_generator.sv
// ----------------------------------------------------------------------------
// Remote encoder frame generator
// Pulse-width coded 12-bit remote-control frame on one output line.
// ----------------------------------------------------------------------------
// Each input transaction is either a time tick or a load of a data byte, and
// each gives exactly one result transaction. The block takes one transaction
// per clock while the queue has room: the front end decodes it into a two-entry
// queue, and the back-end sequencer retires one queue entry per cycle into the
// result register while the output does not stall, so a result passes through
// the queue and then the result register. An output stall holds the result
// register while the queue fills; the input side stalls whenever the queue is
// full, including the cycle in which the queue pops after the output stall ends.
// Configuration is to be written by the user with cfg_we_i only while no
// transaction is in flight; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module remote_encoder_frame_generator #(
  parameter int unsigned TIMER_WIDTH = rfg_pkg::TimerWidthDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rfg_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [rfg_pkg::CfgDataWidth-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             command_i,
  input  logic [rfg_pkg::DataWidth-1:0]    data_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             line_level_o,
  output logic                             busy_res_o,
  output logic                             load_refused_o
);
  import rfg_pkg::*;

  cfg_t    cfg_q, cfg_d;
  logic    push;
  qentry_t push_entry;
  logic    queue_full;
  logic    pop;
  logic    pop_valid;
  qentry_t pop_entry;

  // Register file writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_STATION_ADDRESS: cfg_d.station_address = cfg_data_i[AddrWidth-1:0];
        REG_NARROW_TICKS:    cfg_d.narrow_ticks    = cfg_data_i[LenWidth-1:0];
        REG_WIDE_TICKS:      cfg_d.wide_ticks      = cfg_data_i[LenWidth-1:0];
        REG_SYNC_LOW_TICKS:  cfg_d.sync_low_ticks  = cfg_data_i[LenWidth-1:0];
        REG_REPEAT_COUNT:    cfg_d.repeat_count    = cfg_data_i[RepWidth-1:0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.station_address <= StationAddressReset;
      cfg_q.narrow_ticks    <= NarrowTicksReset;
      cfg_q.wide_ticks      <= WideTicksReset;
      cfg_q.sync_low_ticks  <= SyncLowTicksReset;
      cfg_q.repeat_count    <= RepeatCountReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rfg_front u_front (
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .data_byte_i       (data_byte_i),
    .station_address_i (cfg_q.station_address),
    .push_o            (push),
    .push_entry_o      (push_entry),
    .queue_full_i      (queue_full)
  );

  rfg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (queue_full),
    .pop_i        (pop),
    .pop_valid_o  (pop_valid),
    .pop_entry_o  (pop_entry)
  );

  rfg_back #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .pop_valid_i    (pop_valid),
    .pop_entry_i    (pop_entry),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .line_level_o   (line_level_o),
    .busy_res_o     (busy_res_o),
    .load_refused_o (load_refused_o)
  );

endmodule

// File: sim/remote_encoder_frame_generator_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame generator line checker
// Watches the register port and both channels, tracks the encoder waveform
// state on its own and compares every result transaction against it.
// ----------------------------------------------------------------------------
module remote_encoder_frame_generator_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rfg_pkg::CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [rfg_pkg::CfgDataWidth-1:0] cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic                             command_i,
  input  logic [rfg_pkg::DataWidth-1:0]    data_byte_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic                             line_level_i,
  input  logic                             busy_res_i,
  input  logic                             load_refused_i,
  output int                               fail_count_o,
  output int                               pending_o,
  output logic                             frame_active_o
);
  import rfg_pkg::*;

  // Segments of one data bit, then the two parts of the sync gap
  typedef enum logic [2:0] {
    SEG_HIGH_A    = 3'd0,
    SEG_LOW_A     = 3'd1,
    SEG_HIGH_B    = 3'd2,
    SEG_LOW_B     = 3'd3,
    SEG_SYNC_HIGH = 3'd4,
    SEG_SYNC_LOW  = 3'd5
  } seg_e;

  typedef struct packed {
    logic level;
    logic busy;
    logic refused;
  } line_res_t;

  // Register copies
  logic [AddrWidth-1:0] cfg_addr;
  logic [LenWidth-1:0]  cfg_narrow;
  logic [LenWidth-1:0]  cfg_wide;
  logic [LenWidth-1:0]  cfg_sync_low;
  logic [RepWidth-1:0]  cfg_repeats;

  // Waveform state
  logic [FrameBits-1:0] word_q;
  logic [3:0]           bit_pos;
  seg_e                 seg;
  logic [RepWidth-1:0]  reps_left;
  logic [15:0]          seg_ticks;
  logic                 frame_on;

  line_res_t line_expect_q[$];
  int        mismatches = 0;

  // Print one line per mismatch and count it
  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Step the waveform by one transaction and give the line state it causes
  task automatic advance_waveform(input op_e op, input logic [DataWidth-1:0] data,
                                  output line_res_t r);
    logic                cur_bit;
    logic [LenWidth-1:0] seg_len;
    r = '0;
    if (op == OP_LOAD) begin
      r.busy = 1'b1;
      if (frame_on) begin
        r.refused = 1'b1;
      end else begin
        word_q    = {data, cfg_addr};
        reps_left = (cfg_repeats == '0) ? 4'd1 : cfg_repeats;
        bit_pos   = '0;
        seg       = SEG_HIGH_A;
        seg_ticks = '0;
        frame_on  = 1'b1;
      end
    end else if (frame_on) begin
      cur_bit = word_q[bit_pos];
      r.busy  = 1'b1;
      case (seg)
        SEG_HIGH_A, SEG_HIGH_B: begin
          r.level = 1'b1;
          seg_len = cur_bit ? cfg_wide : cfg_narrow;
        end
        SEG_LOW_A, SEG_LOW_B: begin
          r.level = 1'b0;
          seg_len = cur_bit ? cfg_narrow : cfg_wide;
        end
        SEG_SYNC_HIGH: begin
          r.level = 1'b1;
          seg_len = cfg_narrow;
        end
        default: begin
          r.level = 1'b0;
          seg_len = cfg_sync_low;
        end
      endcase
      // A zero length still lasts one tick
      if (seg_len == '0) begin
        seg_len = 16'd1;
      end
      seg_ticks = seg_ticks + 16'd1;
      if (seg_ticks >= seg_len) begin
        seg_ticks = '0;
        case (seg)
          SEG_HIGH_A, SEG_LOW_A, SEG_HIGH_B: begin
            seg = seg_e'(seg + 3'd1);
          end
          SEG_LOW_B: begin
            if (bit_pos >= 4'(FrameBits - 1)) begin
              seg = SEG_SYNC_HIGH;
            end else begin
              bit_pos = bit_pos + 4'd1;
              seg     = SEG_HIGH_A;
            end
          end
          SEG_SYNC_HIGH: begin
            seg = SEG_SYNC_LOW;
          end
          default: begin
            bit_pos = '0;
            seg     = SEG_HIGH_A;
            if (reps_left <= 4'd1) begin
              reps_left = '0;
              frame_on  = 1'b0;
            end else begin
              reps_left = reps_left - 4'd1;
            end
          end
        endcase
      end
    end
  endtask

  // Track registers and input, compare results in arrival order
  always @(posedge clk_i or negedge rst_ni) begin : watch
    line_res_t want;
    line_res_t seen;
    if (!rst_ni) begin
      cfg_addr     = StationAddressReset;
      cfg_narrow   = NarrowTicksReset;
      cfg_wide     = WideTicksReset;
      cfg_sync_low = SyncLowTicksReset;
      cfg_repeats  = RepeatCountReset;
      word_q       = '0;
      bit_pos      = '0;
      seg          = SEG_HIGH_A;
      reps_left    = '0;
      seg_ticks    = '0;
      frame_on     = 1'b0;
      line_expect_q.delete();
    end else begin
      // Check the outgoing result first, so it never pairs with this cycle's input
      if (out_valid_i && !out_stall_i) begin
        seen = {line_level_i, busy_res_i, load_refused_i};
        if (line_expect_q.size() == 0) begin
          flag_mismatch("result transaction with nothing outstanding");
        end else begin
          want = line_expect_q.pop_front();
          if (seen.level !== want.level) begin
            flag_mismatch($sformatf("line_level got %b want %b", seen.level, want.level));
          end
          if (seen.busy !== want.busy) begin
            flag_mismatch($sformatf("busy_res got %b want %b", seen.busy, want.busy));
          end
          if (seen.refused !== want.refused) begin
            flag_mismatch($sformatf("load_refused got %b want %b",
                                    seen.refused, want.refused));
          end
        end
      end

      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_STATION_ADDRESS: cfg_addr     = cfg_data_i[AddrWidth-1:0];
          REG_NARROW_TICKS:    cfg_narrow   = cfg_data_i;
          REG_WIDE_TICKS:      cfg_wide     = cfg_data_i;
          REG_SYNC_LOW_TICKS:  cfg_sync_low = cfg_data_i;
          REG_REPEAT_COUNT:    cfg_repeats  = cfg_data_i[RepWidth-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        advance_waveform(op_e'(command_i), data_byte_i, want);
        line_expect_q.push_back(want);
      end
    end
    fail_count_o   <= mismatches;
    pending_o      <= line_expect_q.size();
    frame_active_o <= frame_on;
  end

endmodule

// File: sim/remote_encoder_frame_generator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Frame generator testbench
// Drives tick and load transactions with random gaps and output stalls,
// reprograms the segment lengths between bursts and lets the checker judge
// every line result.
// ----------------------------------------------------------------------------
module remote_encoder_frame_generator_test;
  import rfg_pkg::*;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CfgIdxWidth-1:0]  cfg_index_i;
  logic [CfgDataWidth-1:0] cfg_data_i;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic                    command_i;
  logic [DataWidth-1:0]    data_byte_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic                    line_level_o;
  logic                    busy_res_o;
  logic                    load_refused_o;

  int   mismatch_total;
  int   pending_results;
  logic frame_active;

  int   items_sent  = 0;
  int   holds_req   = 0;
  logic quiet_tail  = 1'b0;

  remote_encoder_frame_generator DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .line_level_o   (line_level_o),
    .busy_res_o     (busy_res_o),
    .load_refused_o (load_refused_o)
  );

  remote_encoder_frame_generator_checker line_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .command_i      (command_i),
    .data_byte_i    (data_byte_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .line_level_i   (line_level_o),
    .busy_res_i     (busy_res_o),
    .load_refused_i (load_refused_o),
    .fail_count_o   (mismatch_total),
    .pending_o      (pending_results),
    .frame_active_o (frame_active)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard limit on the run
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  // Result side: short random stalls, plus one long hold-off on request
  initial begin : result_side
    int holds_done;
    holds_done  = 0;
    out_stall_i = 1'b0;
    forever begin
      if (holds_done < holds_req) begin
        out_stall_i <= 1'b1;
        repeat (48) @(posedge clk_i);
        holds_done++;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  // Offer one transaction, with an occasional gap ahead of it, and hold it
  // until taken
  task automatic send_item(input op_e op, input logic [DataWidth-1:0] data);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= op;
    data_byte_i <= data;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Drop valid and wait until every result is back
  task automatic settle_block();
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CfgDataWidth-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  // Nibble register value, sometimes with junk in the unused upper bits
  function automatic logic [CfgDataWidth-1:0] nibble_word(input logic [3:0] v);
    logic [11:0] junk;
    junk = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'h000;
    return {junk, v};
  endfunction

  // Stimulus and verdict
  initial begin : stimulus
    int phase_no;
    int burst;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = REG_STATION_ADDRESS;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    command_i   = OP_TICK;
    data_byte_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Idle tick, load at reset lengths, refused load while busy
    send_item(OP_TICK, 8'h5A);
    send_item(OP_LOAD, 8'h00);
    send_item(OP_LOAD, 8'hFF);
    repeat (6) send_item(OP_TICK, 8'($urandom_range(0, 255)));

    // Shorten the segments mid-frame: zero lengths and zero repeat count
    settle_block();
    write_reg(REG_STATION_ADDRESS, 16'h000F);
    write_reg(REG_NARROW_TICKS, 16'h0000);
    write_reg(REG_WIDE_TICKS, 16'h0001);
    write_reg(REG_SYNC_LOW_TICKS, 16'h0000);
    write_reg(REG_REPEAT_COUNT, 16'h0000);
    repeat (12) send_item(OP_TICK, 8'($urandom_range(0, 255)));
    send_item(OP_LOAD, 8'hA5);

    // Random bursts, each under a fresh register setting
    phase_no = 0;
    while (items_sent < 1100) begin
      settle_block();
      if ($urandom_range(0, 3) != 0) begin
        write_reg(REG_STATION_ADDRESS, nibble_word(4'($urandom_range(0, 15))));
      end
      if ($urandom_range(0, 3) != 0) begin
        write_reg(REG_REPEAT_COUNT, nibble_word(4'($urandom_range(0, 3))));
      end
      case (phase_no)
        3: begin
          write_reg(REG_NARROW_TICKS, 16'hFFFF);
          write_reg(REG_WIDE_TICKS, 16'hFFFF);
          write_reg(REG_SYNC_LOW_TICKS, 16'($urandom_range(0, 6)));
        end
        5: begin
          write_reg(REG_NARROW_TICKS, 16'h0000);
          write_reg(REG_WIDE_TICKS, 16'h0000);
          write_reg(REG_SYNC_LOW_TICKS, 16'h0000);
          write_reg(REG_REPEAT_COUNT, 16'h000F);
        end
        default: begin
          write_reg(REG_NARROW_TICKS, 16'($urandom_range(0, 3)));
          write_reg(REG_WIDE_TICKS, 16'($urandom_range(0, 4)));
          write_reg(REG_SYNC_LOW_TICKS, 16'($urandom_range(0, 6)));
        end
      endcase
      if (phase_no == 1) begin
        holds_req <= holds_req + 1;
      end
      burst = $urandom_range(40, 160);
      repeat (burst) begin
        // Loads mostly when idle, now and then into a running frame
        if (frame_active ? ($urandom_range(0, 29) == 0) : ($urandom_range(0, 3) == 0)) begin
          send_item(OP_LOAD, 8'($urandom_range(0, 255)));
        end else begin
          send_item(OP_TICK, 8'($urandom_range(0, 255)));
        end
      end
      phase_no++;
    end

    // Quiet tail: finish any frame quickly, then one frame with a long sync
    quiet_tail <= 1'b1;
    settle_block();
    write_reg(REG_NARROW_TICKS, 16'h0001);
    write_reg(REG_WIDE_TICKS, 16'h0001);
    write_reg(REG_SYNC_LOW_TICKS, 16'h0001);
    while (frame_active) send_item(OP_TICK, 8'($urandom_range(0, 255)));
    settle_block();
    write_reg(REG_STATION_ADDRESS, 16'($urandom_range(0, 15)));
    write_reg(REG_WIDE_TICKS, 16'h0000);
    write_reg(REG_SYNC_LOW_TICKS, 16'd300);
    write_reg(REG_REPEAT_COUNT, 16'h0001);
    send_item(OP_LOAD, 8'($urandom_range(0, 255)));
    while (frame_active) send_item(OP_TICK, 8'($urandom_range(0, 255)));
    repeat (4) send_item(OP_TICK, 8'($urandom_range(0, 255)));
    in_valid_i <= 1'b0;

    // Drain and judge
    repeat (2) @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_total == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
